// ----- src/hnf_pkg.sv -----
package hnf_pkg;

  localparam int NORM_LAT = 64;
  localparam int PIPE_LAT = 1 + NORM_LAT + 1 + NORM_LAT;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 25;
  localparam int FRAC_INNER = 24;
  localparam int FRAC_OUTER = 14;
  localparam logic [15:0] GRID_STEP_RST = 16'd256;

  typedef logic signed [31:0] comp_t;
  typedef logic signed [25:0] unit_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
  } frame_t;

  typedef struct packed {
    logic [2:0][29:0] mag;
    logic [2:0]       sgn;
    logic             zero;
  } side_t;

endpackage

// ----- src/hnf_if.sv -----
interface hnf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] h_center;
  logic signed [15:0] h_left;
  logic signed [15:0] h_back;
  logic signed [15:0] h_right;
  logic signed [15:0] h_front;

  modport source(output valid, h_center, h_left, h_back, h_right, h_front, input ready);
  modport sink(input valid, h_center, h_left, h_back, h_right, h_front, output ready);
endinterface

interface hnf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_y;
  logic signed [15:0] tangent_z;
  logic signed [15:0] bitangent_x;
  logic signed [15:0] bitangent_y;
  logic signed [15:0] bitangent_z;

  modport source(output valid, normal_x, normal_y, normal_z, tangent_x, tangent_y,
                 tangent_z, bitangent_x, bitangent_y, bitangent_z, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, tangent_x, tangent_y,
               tangent_z, bitangent_x, bitangent_y, bitangent_z, output ready);
endinterface

interface hnf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] grid_step;

  modport source(output valid, grid_step, input ready);
  modport sink(input valid, grid_step, output ready);
endinterface

// ----- src/hnf_norm.sv -----
module hnf_norm (
  input  logic          clk,
  input  logic          en,
  input  logic          outer,
  input  hnf_pkg::comp_t v [3],
  output hnf_pkg::unit_t u [3]
);

  localparam int NS = hnf_pkg::SQRT_STEPS;
  localparam int ND = hnf_pkg::DIV_STEPS;

  logic [29:0]    mag1_r [3];
  logic [2:0]     sgn1_r;
  hnf_pkg::side_t side2_r;
  hnf_pkg::side_t side3_r;
  hnf_pkg::side_t side4_r;
  logic [59:0]    sq4_r [3];

  logic [63:0]    rem_r  [0:NS];
  logic [63:0]    root_r [0:NS];
  hnf_pkg::side_t rsd_r  [0:NS];

  logic [63:0]    dv_r [0:ND][3];
  logic [24:0]    qt_r [0:ND][3];
  logic [30:0]    m_r  [0:ND];
  logic [2:0]     dsgn_r [0:ND];
  logic           dzero_r [0:ND];

  logic [29:0] top1, top1s, top2, top2a, top2b;
  logic        sh16, sh8, sh4, sh2, sh1;
  logic [4:0]  amt2, amt3;

  // stage 1: magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        mag1_r[c] <= v[c][31] ? 30'(-v[c]) : v[c][29:0];
        sgn1_r[c] <= v[c][31];
      end
    end
  end

  // stages 2-3: left-justify so the largest magnitude has bit 29 set
  always_comb begin
    top1  = mag1_r[0] | mag1_r[1] | mag1_r[2];
    sh16  = (top1[29:14] == '0);
    top1s = sh16 ? (top1 << 16) : top1;
    sh8   = (top1s[29:22] == '0);
    amt2  = {sh16, sh8, 3'b000};
    top2  = side2_r.mag[0] | side2_r.mag[1] | side2_r.mag[2];
    sh4   = (top2[29:26] == '0);
    top2a = sh4 ? (top2 << 4) : top2;
    sh2   = (top2a[29:28] == '0);
    top2b = sh2 ? (top2a << 2) : top2a;
    sh1   = ~top2b[29];
    amt3  = {2'b00, sh4, sh2, sh1};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        side2_r.mag[c] <= mag1_r[c] << amt2;
        side3_r.mag[c] <= side2_r.mag[c] << amt3;
      end
      side2_r.sgn  <= sgn1_r;
      side2_r.zero <= (top1 == '0);
      side3_r.sgn  <= side2_r.sgn;
      side3_r.zero <= side2_r.zero;
    end
  end

  // stages 4-5: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq4_r[c] <= side3_r.mag[c] * side3_r.mag[c];
      end
      side4_r   <= side3_r;
      rem_r[0]  <= 64'(sq4_r[0]) + 64'(sq4_r[1]) + 64'(sq4_r[2]);
      root_r[0] <= '0;
      rsd_r[0]  <= side4_r;
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (NS - 1 - j));
    logic [63:0] trial;
    assign trial = root_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[j] >= trial) begin
          rem_r[j+1]  <= rem_r[j] - trial;
          root_r[j+1] <= (root_r[j] >> 1) + BIT;
        end else begin
          rem_r[j+1]  <= rem_r[j];
          root_r[j+1] <= root_r[j] >> 1;
        end
        rsd_r[j+1] <= rsd_r[j];
      end
    end
  end

  // dividend set-up with half-divisor rounding
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dv_r[0][c] <= (outer ? (64'(rsd_r[NS].mag[c]) << hnf_pkg::FRAC_OUTER)
                             : (64'(rsd_r[NS].mag[c]) << hnf_pkg::FRAC_INNER))
                      + 64'(root_r[NS][30:1]);
        qt_r[0][c] <= '0;
      end
      m_r[0]     <= root_r[NS][30:0];
      dsgn_r[0]  <= rsd_r[NS].sgn;
      dzero_r[0] <= rsd_r[NS].zero;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [63:0] dsr;
    assign dsr = 64'(m_r[j]) << (ND - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          if (dv_r[j][c] >= dsr) begin
            dv_r[j+1][c] <= dv_r[j][c] - dsr;
            qt_r[j+1][c] <= {qt_r[j][c][23:0], 1'b1};
          end else begin
            dv_r[j+1][c] <= dv_r[j][c];
            qt_r[j+1][c] <= {qt_r[j][c][23:0], 1'b0};
          end
        end
        m_r[j+1]     <= m_r[j];
        dsgn_r[j+1]  <= dsgn_r[j];
        dzero_r[j+1] <= dzero_r[j];
      end
    end
  end

  // sign restore
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        if (dzero_r[ND]) begin
          u[c] <= '0;
        end else if (dsgn_r[ND][c]) begin
          u[c] <= -$signed({1'b0, qt_r[ND][c]});
        end else begin
          u[c] <= $signed({1'b0, qt_r[ND][c]});
        end
      end
    end
  end

endmodule

// ----- src/heightfield_normal_frame_unit.sv -----
// Heightfield vertex frame unit.
// in_ch carries one vertex per transaction: center height and the four
// neighbor heights, signed Q8.8. out_ch returns one transaction per vertex
// with unit normal, tangent and bitangent, signed Q1.14, in input order.
// cfg_ch writes grid_step (unsigned Q8.8); write it only while idle.
// Throughput: one vertex per cycle while the output buffer has room. The path
// from the input transaction to out_ch.valid runs through an input register,
// two chained normalizers of 64 stages each (square root 32 stages, divide
// 25 stages), a sum register and the output buffer write.
// Reset (rst_n low, synchronous) empties the pipeline and the output buffer
// and sets grid_step to 256.
// The output sits in a two-entry buffer. When out_ch.ready is low and the
// buffer fills, the whole pipeline holds and in_ch.ready drops; nothing is
// lost or repeated. in_ch.ready depends on registers only.
module heightfield_normal_frame_unit (
  input logic      clk,
  input logic      rst_n,
  hnf_in_if.sink   in_ch,
  hnf_out_if.source out_ch,
  hnf_cfg_if.sink  cfg_ch
);

  localparam int PL = hnf_pkg::PIPE_LAT;

  logic [15:0]        grid_step_r;
  logic               adv;
  logic               in_fire;
  logic [PL-1:0]      vld_r;
  logic signed [16:0] dl_r, db_r, dr_r, df_r, s_r;

  hnf_pkg::comp_t nl, nb, nr, nf, sc, zc;
  hnf_pkg::comp_t fv [8][3];
  hnf_pkg::unit_t fu [8][3];
  hnf_pkg::comp_t acc_r [3][3];
  hnf_pkg::unit_t ou [3][3];

  hnf_pkg::frame_t fifo_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, pop;
  hnf_pkg::frame_t head;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_step_r <= hnf_pkg::GRID_STEP_RST;
    end else if (cfg_ch.valid) begin
      grid_step_r <= cfg_ch.grid_step;
    end
  end

  assign adv         = (cnt_r != 2'd2);
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid & adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PL-2:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r <= 17'(in_ch.h_left)  - 17'(in_ch.h_center);
      db_r <= 17'(in_ch.h_back)  - 17'(in_ch.h_center);
      dr_r <= 17'(in_ch.h_right) - 17'(in_ch.h_center);
      df_r <= 17'(in_ch.h_front) - 17'(in_ch.h_center);
      s_r  <= $signed({1'b0, grid_step_r});
    end
  end

  always_comb begin
    nl = 32'(dl_r);
    nb = 32'(db_r);
    nr = 32'(dr_r);
    nf = 32'(df_r);
    sc = 32'(s_r);
    zc = '0;
    fv[0][0] = -nr; fv[0][1] = sc; fv[0][2] = -nf;
    fv[1][0] = -nr; fv[1][1] = sc; fv[1][2] = nb;
    fv[2][0] = nl;  fv[2][1] = sc; fv[2][2] = nb;
    fv[3][0] = nl;  fv[3][1] = sc; fv[3][2] = -nf;
    fv[4][0] = sc;  fv[4][1] = -nl; fv[4][2] = zc;
    fv[5][0] = sc;  fv[5][1] = nr;  fv[5][2] = zc;
    fv[6][0] = zc;  fv[6][1] = nb;  fv[6][2] = -sc;
    fv[7][0] = zc;  fv[7][1] = -nf; fv[7][2] = -sc;
  end

  for (genvar k = 0; k < 8; k++) begin : g_inner
    hnf_norm u_norm (
      .clk   (clk),
      .en    (adv),
      .outer (1'b0),
      .v     (fv[k]),
      .u     (fu[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[0][c] <= 32'(fu[0][c]) + 32'(fu[1][c]) + 32'(fu[2][c]) + 32'(fu[3][c]);
        acc_r[1][c] <= 32'(fu[4][c]) + 32'(fu[5][c]);
        acc_r[2][c] <= 32'(fu[6][c]) + 32'(fu[7][c]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_outer
    hnf_norm u_norm (
      .clk   (clk),
      .en    (adv),
      .outer (1'b1),
      .v     (acc_r[k]),
      .u     (ou[k])
    );
  end

  // output buffer
  assign push = vld_r[PL-1] & adv;
  assign pop  = out_ch.valid & out_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= '{normal_x:    ou[0][0][15:0], normal_y:    ou[0][1][15:0],
                        normal_z:    ou[0][2][15:0], tangent_x:   ou[1][0][15:0],
                        tangent_y:   ou[1][1][15:0], tangent_z:   ou[1][2][15:0],
                        bitangent_x: ou[2][0][15:0], bitangent_y: ou[2][1][15:0],
                        bitangent_z: ou[2][2][15:0]};
    end
  end

  assign head               = fifo_r[rp_r];
  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.normal_x    = head.normal_x;
  assign out_ch.normal_y    = head.normal_y;
  assign out_ch.normal_z    = head.normal_z;
  assign out_ch.tangent_x   = head.tangent_x;
  assign out_ch.tangent_y   = head.tangent_y;
  assign out_ch.tangent_z   = head.tangent_z;
  assign out_ch.bitangent_x = head.bitangent_x;
  assign out_ch.bitangent_y = head.bitangent_y;
  assign out_ch.bitangent_z = head.bitangent_z;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("output buffer count out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r)) else $error("pipeline moved while stalled");

  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_ch.valid) else $error("pushed transaction not presented");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !push) else $error("push into full output buffer");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;

  typedef logic [2:0][63:0] v3_t;

  class frame_scoreboard;
    logic [15:0]     step;
    hnf_pkg::frame_t pending[$];
    int              errors;
    int              checked;

    function new();
      step = hnf_pkg::GRID_STEP_RST;
      errors = 0;
      checked = 0;
    endfunction

    function v3_t mk3(longint x, longint y, longint z);
      v3_t o;
      o[0] = x;
      o[1] = y;
      o[2] = z;
      return o;
    endfunction

    function v3_t add3(v3_t a, v3_t b);
      v3_t o;
      for (int i = 0; i < 3; i++) o[i] = a[i] + b[i];
      return o;
    endfunction

    // scale so the largest magnitude reaches 2^29, then divide by isqrt of the sum of squares
    function v3_t unit_vec(v3_t v, int frac);
      longint unsigned mag[3];
      longint unsigned top, q, m, c, bitv;
      v3_t o;
      top = 0;
      q = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = v[i][63] ? -v[i] : v[i];
        if (mag[i] > top) top = mag[i];
      end
      if (top == 0) return '0;
      while (top < (64'd1 << 29)) begin
        top = top << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      for (int i = 0; i < 3; i++) q += mag[i] * mag[i];
      m = 0;
      bitv = 64'd1 << 62;
      while (bitv > q) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (q >= m + bitv) begin
          q = q - (m + bitv);
          m = (m >> 1) + bitv;
        end else begin
          m = m >> 1;
        end
        bitv = bitv >> 2;
      end
      for (int i = 0; i < 3; i++) begin
        c = ((mag[i] << frac) + (m >> 1)) / m;
        o[i] = v[i][63] ? -c : c;
      end
      return o;
    endfunction

    function hnf_pkg::frame_t vertex_frame(logic signed [15:0] hc, hl, hb, hr, hf);
      longint dl, db, dr, df, s;
      v3_t acc, res;
      hnf_pkg::frame_t f;
      dl = longint'(hl) - longint'(hc);
      db = longint'(hb) - longint'(hc);
      dr = longint'(hr) - longint'(hc);
      df = longint'(hf) - longint'(hc);
      s = longint'({48'd0, step});
      acc = add3(unit_vec(mk3(-dr, s, -df), hnf_pkg::FRAC_INNER),
                 unit_vec(mk3(-dr, s, db), hnf_pkg::FRAC_INNER));
      acc = add3(acc, unit_vec(mk3(dl, s, db), hnf_pkg::FRAC_INNER));
      acc = add3(acc, unit_vec(mk3(dl, s, -df), hnf_pkg::FRAC_INNER));
      res = unit_vec(acc, hnf_pkg::FRAC_OUTER);
      f.normal_x = res[0][15:0];
      f.normal_y = res[1][15:0];
      f.normal_z = res[2][15:0];
      acc = add3(unit_vec(mk3(s, -dl, 0), hnf_pkg::FRAC_INNER),
                 unit_vec(mk3(s, dr, 0), hnf_pkg::FRAC_INNER));
      res = unit_vec(acc, hnf_pkg::FRAC_OUTER);
      f.tangent_x = res[0][15:0];
      f.tangent_y = res[1][15:0];
      f.tangent_z = res[2][15:0];
      acc = add3(unit_vec(mk3(0, db, -s), hnf_pkg::FRAC_INNER),
                 unit_vec(mk3(0, -df, -s), hnf_pkg::FRAC_INNER));
      res = unit_vec(acc, hnf_pkg::FRAC_OUTER);
      f.bitangent_x = res[0][15:0];
      f.bitangent_y = res[1][15:0];
      f.bitangent_z = res[2][15:0];
      return f;
    endfunction

    function void note_vertex(logic signed [15:0] hc, hl, hb, hr, hf);
      pending.push_back(vertex_frame(hc, hl, hb, hr, hf));
    endfunction

    function void check_frame(hnf_pkg::frame_t got);
      string names[9] = '{"normal_x", "normal_y", "normal_z", "tangent_x", "tangent_y",
                          "tangent_z", "bitangent_x", "bitangent_y", "bitangent_z"};
      hnf_pkg::frame_t exp_f;
      logic [143:0] e, g;
      if (pending.size() == 0) begin
        $error("unexpected output transaction");
        errors++;
        return;
      end
      exp_f = pending.pop_front();
      e = exp_f;
      g = got;
      checked++;
      for (int i = 0; i < 9; i++)
        if (e[143 - 16*i -: 16] !== g[143 - 16*i -: 16]) begin
          $error("%s: expected %0d, got %0d", names[i],
                 $signed(e[143 - 16*i -: 16]), $signed(g[143 - 16*i -: 16]));
          errors++;
        end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   hold_cycles;
  int   sent;
  frame_scoreboard sb;

  hnf_in_if  in_ch();
  hnf_out_if out_ch();
  hnf_cfg_if cfg_ch();

  heightfield_normal_frame_unit DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int burst;
    out_ch.ready = 0;
    burst = 0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_frame('{out_ch.normal_x, out_ch.normal_y, out_ch.normal_z,
                         out_ch.tangent_x, out_ch.tangent_y, out_ch.tangent_z,
                         out_ch.bitangent_x, out_ch.bitangent_y, out_ch.bitangent_z});
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 0;
      end else if (burst > 0) begin
        burst--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
        if (!no_idle && $urandom_range(0, 7) == 0) burst = $urandom_range(1, 17);
      end
    end
  end

  task automatic send_vertex(logic signed [15:0] hc, hl, hb, hr, hf, bit gaps);
    in_ch.valid <= 1;
    in_ch.h_center <= hc;
    in_ch.h_left <= hl;
    in_ch.h_back <= hb;
    in_ch.h_right <= hr;
    in_ch.h_front <= hf;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_vertex(hc, hl, hb, hr, hf);
    sent++;
    if (gaps && !no_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_random(bit gaps);
    logic signed [15:0] hc;
    logic signed [15:0] d[4];
    hc = 16'($urandom);
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 3))
        0: d[i] = 16'($urandom);
        1: d[i] = hc + $signed(16'($urandom_range(0, 63)) - 16'sd32);
        default: d[i] = hc + $signed(16'($urandom_range(0, 2047)) - 16'sd1024);
      endcase
    end
    send_vertex(hc, d[0], d[1], d[2], d[3], gaps);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (hnf_pkg::PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic write_step(logic [15:0] value);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.grid_step <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    sb.step = value;
  endtask

  initial begin
    logic [15:0] steps[6];
    sb = new();
    no_idle = 0;
    hold_cycles = 0;
    sent = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.h_center = 0;
    in_ch.h_left = 0;
    in_ch.h_back = 0;
    in_ch.h_right = 0;
    in_ch.h_front = 0;
    cfg_ch.valid = 0;
    cfg_ch.grid_step = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_vertex(0, 0, 0, 0, 0, 1);
    send_vertex(-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1);
    send_vertex(16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1);
    send_vertex(0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1);
    send_vertex(0, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1);
    send_vertex(100, 100, 100, 100, 100, 1);
    send_vertex(0, 256, 0, -256, 0, 1);
    send_vertex(0, 0, 256, 0, -256, 1);
    send_vertex(0, -1, -1, -1, -1, 1);
    send_vertex(-1, 0, 0, 0, 0, 1);
    send_vertex(16'sd32767, 16'sd32767, 0, 0, 16'sd32767, 1);

    steps[0] = 16'd1;
    steps[1] = 16'd65535;
    steps[2] = 16'($urandom_range(1, 65535));
    steps[3] = 16'($urandom_range(1, 64));
    steps[4] = 16'($urandom_range(1024, 65535));
    steps[5] = 16'd256;
    for (int p = 0; p < 6; p++) begin
      write_step(steps[p]);
      send_vertex(0, 0, 0, 0, 0, 1);
      send_vertex(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1);
      if (p == 1) begin
        hold_cycles = 400;
        repeat (300) send_random(0);
      end else begin
        if (p == 5) no_idle = 1;
        repeat (195) send_random(1);
      end
      if (p == 3) drain();
    end

    drain();
    $display("Sent %0d vertices over %0d grid spacings, %0d frames checked.",
             sent, 7, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
